// ===== rtl/baro_pressure_temp_compensation_defines.svh =====
// Assertion macros for the barometric compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpc: same-cycle check failed");
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpc: next-cycle check failed");
`else
`define BPC_ASSERT_NOW(lbl, ante, cons)
`define BPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
package bpc_pkg;

    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

    localparam logic signed [19:0] TEMP_REF = 20'sd2000;
    localparam logic signed [27:0] PRES_MAX = 28'sd4194303;
    localparam logic signed [27:0] PRES_MIN = -28'sd4194304;

endpackage

// ===== rtl/bpc_cal_regs.sv =====
// Calibration word register file with write decode.
module bpc_cal_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [bpc_pkg::CAL_W-1:0]      i_data,
    output bpc_pkg::t_cal                  o_cal
);
    import bpc_pkg::*;

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_we) begin
            case (i_index)
                REG_C1: begin
                    r_cal.c1 <= i_data;
                end
                REG_C2: begin
                    r_cal.c2 <= i_data;
                end
                REG_C3: begin
                    r_cal.c3 <= i_data;
                end
                REG_C4: begin
                    r_cal.c4 <= i_data;
                end
                REG_C5: begin
                    r_cal.c5 <= i_data;
                end
                REG_C6: begin
                    r_cal.c6 <= i_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Top level: pipelined second-order temperature and pressure compensation.
// One pair of raw readings enters per beat; its compensated temperature and pressure leave
// stage 9. The pipeline sustains one beat per cycle, each stage stalling only when it is
// full and the next stage cannot take its data, so bubbles close up under back-pressure.
// Stage boundaries fall around the multipliers; the widest is the 24 x 38-bit pressure
// product, split into two partial products and summed a stage later. The user must write
// calibration words through the write port while no beat is in flight; it is not enforced.
`include "baro_pressure_temp_compensation_defines.svh"
module baro_pressure_temp_compensation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [23:0]                    i_raw_temperature,
    input  logic [23:0]                    i_raw_pressure,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [18:0]             o_temperature_centideg,
    output logic signed [22:0]             o_pressure_pa
);
    import bpc_pkg::*;

    localparam int NS = 9;

    t_cal cal;

    bpc_cal_regs u_cal_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cal   (cal)
    );

    // stall control
    logic [NS:1]   r_vld;
    logic [NS:1]   n_vld;
    logic [NS+1:1] stg_en;

    always_comb begin
        stg_en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign n_vld = {r_vld[NS-1:1], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_ready = stg_en[1];
    assign o_valid = r_vld[NS];

    // stage 1: dT
    logic signed [24:0] n1_dt, r1_dt;
    logic        [23:0] r1_d1;

    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r1_dt <= n1_dt;
            r1_d1 <= i_raw_pressure;
        end
    end

    // stage 2: products with dT
    logic signed [16:0] c6s, c4s, c3s;
    logic signed [41:0] n2_pt, n2_po, n2_ps, r2_pt, r2_po, r2_ps;
    logic signed [49:0] n2_pdd;
    logic        [47:0] r2_pdd;
    logic        [23:0] r2_d1;

    assign c6s    = $signed({1'b0, cal.c6});
    assign c4s    = $signed({1'b0, cal.c4});
    assign c3s    = $signed({1'b0, cal.c3});
    assign n2_pt  = r1_dt * c6s;
    assign n2_po  = r1_dt * c4s;
    assign n2_ps  = r1_dt * c3s;
    assign n2_pdd = r1_dt * r1_dt;

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r2_pt  <= n2_pt;
            r2_po  <= n2_po;
            r2_ps  <= n2_ps;
            r2_pdd <= n2_pdd[47:0];
            r2_d1  <= r1_d1;
        end
    end

    // stage 3: first-order TEMP, OFF, SENS; T2
    logic signed [41:0] q_t, q_o, q_s;
    logic signed [19:0] n3_temp1, r3_temp1;
    logic signed [34:0] n3_off1, r3_off1;
    logic signed [33:0] n3_sens1, r3_sens1;
    logic        [16:0] r3_t2;
    logic        [23:0] r3_d1;

    // truncating division toward zero
    assign q_t = (r2_pt + (r2_pt[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    assign q_o = (r2_po + (r2_po[41] ? 42'sd127 : 42'sd0)) >>> 7;
    assign q_s = (r2_ps + (r2_ps[41] ? 42'sd255 : 42'sd0)) >>> 8;

    assign n3_temp1 = TEMP_REF + $signed(q_t[19:0]);
    assign n3_off1  = $signed({3'b000, cal.c2, 16'h0000}) + $signed(q_o[34:0]);
    assign n3_sens1 = $signed({3'b000, cal.c1, 15'h0000}) + $signed(q_s[33:0]);

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r3_temp1 <= n3_temp1;
            r3_off1  <= n3_off1;
            r3_sens1 <= n3_sens1;
            r3_t2    <= r2_pdd[47:31];
            r3_d1    <= r2_d1;
        end
    end

    // stage 4: low-temperature test, (2000-TEMP)^2, corrected TEMP
    logic               n4_low, r4_low;
    logic signed [19:0] diff_full;
    logic        [33:0] n4_sq, r4_sq;
    logic signed [19:0] n4_temp, r4_temp;
    logic signed [34:0] r4_off1;
    logic signed [33:0] r4_sens1;
    logic        [23:0] r4_d1;

    assign n4_low    = r3_temp1 < TEMP_REF;
    assign diff_full = TEMP_REF - r3_temp1;
    assign n4_sq     = diff_full[16:0] * diff_full[16:0];
    assign n4_temp   = n4_low ? r3_temp1 - $signed({3'b000, r3_t2}) : r3_temp1;

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r4_low   <= n4_low;
            r4_sq    <= n4_sq;
            r4_temp  <= n4_temp;
            r4_off1  <= r3_off1;
            r4_sens1 <= r3_sens1;
            r4_d1    <= r3_d1;
        end
    end

    // stage 5: OFF2 and SENS2 applied
    logic        [36:0] five_sq;
    logic signed [37:0] off_ext, sens_ext;
    logic signed [37:0] n5_off, n5_sens, r5_off, r5_sens;
    logic signed [19:0] r5_temp;
    logic        [23:0] r5_d1;

    assign five_sq  = {1'b0, r4_sq, 2'b00} + {3'b000, r4_sq};
    assign off_ext  = {{3{r4_off1[34]}}, r4_off1};
    assign sens_ext = {{4{r4_sens1[33]}}, r4_sens1};
    assign n5_off   = r4_low ? off_ext - $signed({2'b00, five_sq[36:1]}) : off_ext;
    assign n5_sens  = r4_low ? sens_ext - $signed({3'b000, five_sq[36:2]}) : sens_ext;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r5_off  <= n5_off;
            r5_sens <= n5_sens;
            r5_temp <= r4_temp;
            r5_d1   <= r4_d1;
        end
    end

    // stage 6: D1*SENS as two partial products
    logic        [42:0] n6_mlo, r6_mlo;
    logic signed [43:0] n6_mhi, r6_mhi;
    logic signed [18:0] sens_hi;
    logic signed [37:0] r6_off;
    logic signed [19:0] r6_temp;

    assign sens_hi = $signed(r5_sens[37:19]);
    assign n6_mlo  = r5_d1 * r5_sens[18:0];
    assign n6_mhi  = $signed({1'b0, r5_d1}) * sens_hi;

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r6_mlo  <= n6_mlo;
            r6_mhi  <= n6_mhi;
            r6_off  <= r5_off;
            r6_temp <= r5_temp;
        end
    end

    // stage 7: partial product sum
    logic signed [62:0] n7_prod, r7_prod;
    logic signed [37:0] r7_off;
    logic signed [19:0] r7_temp;

    assign n7_prod = $signed({r6_mhi, 19'h00000}) + $signed({20'h00000, r6_mlo});

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r7_prod <= n7_prod;
            r7_off  <= r6_off;
            r7_temp <= r6_temp;
        end
    end

    // stage 8: D1*SENS/2^21 - OFF
    logic signed [62:0] q_p;
    logic signed [42:0] n8_x, r8_x;
    logic signed [19:0] r8_temp;

    assign q_p  = (r7_prod + (r7_prod[62] ? 63'sd2097151 : 63'sd0)) >>> 21;
    assign n8_x = $signed({q_p[41], q_p[41:0]}) - $signed({{5{r7_off[37]}}, r7_off});

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r8_x    <= n8_x;
            r8_temp <= r7_temp;
        end
    end

    // stage 9: /2^15, saturate, output register
    logic signed [42:0] q_x;
    logic signed [27:0] p_wide;
    logic signed [22:0] n9_p, r9_p;
    logic signed [18:0] r9_temp;

    assign q_x    = (r8_x + (r8_x[42] ? 43'sd32767 : 43'sd0)) >>> 15;
    assign p_wide = q_x[27:0];

    always_comb begin
        if (p_wide > PRES_MAX) begin
            n9_p = PRES_MAX[22:0];
        end else if (p_wide < PRES_MIN) begin
            n9_p = PRES_MIN[22:0];
        end else begin
            n9_p = p_wide[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[9]) begin
            r9_p    <= n9_p;
            r9_temp <= r8_temp[18:0];
        end
    end

    assign o_temperature_centideg = r9_temp;
    assign o_pressure_pa          = r9_p;

    `BPC_ASSERT_NOW(a_stall_only_when_full, !o_ready, r_vld[1])
    `BPC_ASSERT_NEXT(a_accept_fills_entry, i_valid && o_ready, r_vld[1])
    `BPC_ASSERT_NOW(a_warm_uncorrected, r_vld[4] && !r4_low, r4_temp >= TEMP_REF)

endmodule
